@@ hw/rtl/slc_pkg.sv @@
// Shared types, widths and constants of the single-level conductance pipeline.
// No dependencies; the cordic, divider and top-level modules import it.
`default_nettype none

package slc_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int QUO_BITS     = 32;
   localparam int DIV_W        = 72;
   localparam int CW           = 45;
   localparam int MW           = 42;
   localparam int Z_W          = 34;
   localparam int NUM_W        = 100;
   localparam int NORM_TOP     = 41;

   localparam logic [16:0] ETA_ONE   = 17'd65536;
   localparam logic [16:0] ETA_RESET = 17'd32768;
   localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

   // pipeline stage indexes
   localparam int ST_CORDIC  = 7;
   localparam int ST_DZ      = ST_CORDIC + CORDIC_STEPS;
   localparam int ST_ABS     = ST_DZ + 1;
   localparam int ST_MUL     = ST_DZ + 2;
   localparam int ST_NUM     = ST_DZ + 3;
   localparam int ST_DIVIN   = ST_DZ + 4;
   localparam int ST_DIV0    = ST_DZ + 5;
   localparam int ST_MIX     = ST_DIV0 + QUO_BITS;
   localparam int ST_OUT     = ST_MIX + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef enum logic [1:0] {
      CMD_TRANS  = 2'd0,
      CMD_STATIC = 2'd1,
      CMD_DIFF   = 2'd2,
      CMD_NONE   = 2'd3
   } slc_cmd_type;

   typedef struct packed {
      logic [DIV_W-1:0]    rem;
      logic [DIV_W-1:0]    den;
      logic [QUO_BITS-1:0] low;
   } slc_div_in_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [MW-1:0]        m;
   } slc_norm_type;

   typedef struct packed {
      slc_cmd_type          cmd;
      logic                 fault;
      logic [16:0]          eta;
      logic signed [31:0]   e;
      logic signed [31:0]   eps;
      logic signed [31:0]   v;
      logic [30:0]          gl;
      logic [30:0]          gr;
      logic signed [32:0]   dd;
      logic [31:0]          s;
      logic [61:0]          glgr;
      logic signed [49:0]   aprod;
      logic signed [33:0]   a;
      logic signed [35:0]   u1;
      logic signed [35:0]   u2;
      logic [35:0]          mag_a;
      logic [35:0]          mag_b;
      slc_norm_type         lane1;
      slc_norm_type         lane2;
      logic [63:0]          sqa_lo;
      logic [35:0]          sqa_mid;
      logic [7:0]           sqa_hi;
      logic [63:0]          sqb_lo;
      logic [35:0]          sqb_mid;
      logic [7:0]           sqb_hi;
      logic [63:0]          ss;
      logic [DIV_W-1:0]     den_a;
      logic [DIV_W-1:0]     den_b;
      logic signed [Z_W-1:0] dz;
      logic [Z_W-1:0]       abs_dz;
      logic                 sgn_ok;
      logic [31:0]          abs_v;
      logic [65:0]          plo;
      logic [63:0]          phi;
      logic [63:0]          den_s;
      logic [NUM_W-1:0]     num_s;
      logic                 sat;
      slc_div_in_type       div_a;
      slc_div_in_type       div_b;
      logic [31:0]          q_a;
      logic [48:0]          pa;
      logic [48:0]          pb;
      logic [31:0]          conductance;
      logic                 status;
   } slc_item_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         5'd24: r = 32'h0000003F;
         5'd25: r = 32'h0000001F;
         5'd26: r = 32'h0000000F;
         5'd27: r = 32'h00000008;
         5'd28: r = 32'h00000004;
         5'd29: r = 32'h00000002;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic [35:0] abs36(input logic signed [35:0] d);
      return d[35] ? 36'(-d) : 36'(d);
   endfunction

   // three greedy left shifts: base, base/2, base/4; keep m below 2^NORM_TOP
   function automatic slc_norm_type norm3(input slc_norm_type n, input int base);
      slc_norm_type r;
      int sh;
      r = n;
      for (int k = 0; k < 3; k++) begin
         sh = base >> k;
         if ((r.m >> (NORM_TOP - sh)) == '0) begin
            r.m = r.m << sh;
            r.x = r.x <<< sh;
            r.y = r.y <<< sh;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/slc_cordic.sv @@
// Pipelined vectoring CORDIC: one rotation per register stage, angle out in Q4.30.
// Depends on slc_pkg for widths, step count and the arctangent table.
`default_nettype none

module slc_cordic import slc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic signed [CW-1:0]  x_in,
   input  wire logic signed [CW-1:0]  y_in,
   output logic signed [Z_W-1:0]      z_out
);

   logic signed [CW-1:0]  x_ff [CORDIC_STEPS];
   logic signed [CW-1:0]  y_ff [CORDIC_STEPS];
   logic signed [Z_W-1:0] z_ff [CORDIC_STEPS];
   logic signed [CW-1:0]  x_in_s [CORDIC_STEPS];
   logic signed [CW-1:0]  y_in_s [CORDIC_STEPS];
   logic signed [Z_W-1:0] z_in_s [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CW-1:0]  xp;
      logic signed [CW-1:0]  yp;
      logic signed [Z_W-1:0] zp;
      logic signed [Z_W-1:0] t;
      if (i == 0) begin : g_first
         assign xp = x_in;
         assign yp = y_in;
         assign zp = '0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end
      assign t = Z_W'({1'b0, atan_entry(5'(i))});

      always_comb begin
         if (yp < 0) begin
            x_in_s[i] = xp - (yp >>> i);
            y_in_s[i] = yp + (xp >>> i);
            z_in_s[i] = zp - t;
         end else begin
            x_in_s[i] = xp + (yp >>> i);
            y_in_s[i] = yp - (xp >>> i);
            z_in_s[i] = zp + t;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i] <= x_in_s[i];
            y_ff[i] <= y_in_s[i];
            z_ff[i] <= z_in_s[i];
         end
      end
   end

   assign z_out = z_ff[CORDIC_STEPS-1];

endmodule

`default_nettype wire

@@ hw/rtl/slc_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on slc_pkg for widths and the divider input struct.
`default_nettype none

module slc_div import slc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           enable,
   input  wire slc_div_in_type div_in,
   output logic [QUO_BITS-1:0] quotient
);

   logic [DIV_W-1:0]    rem_ff [QUO_BITS];
   logic [DIV_W-1:0]    den_ff [QUO_BITS];
   logic [QUO_BITS-1:0] low_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
      logic [DIV_W-1:0]    rp;
      logic [DIV_W-1:0]    dp;
      logic [QUO_BITS-1:0] lp;
      logic [QUO_BITS-1:0] qp;
      logic [DIV_W:0]      t;
      logic                ge;
      if (k == 0) begin : g_first
         assign rp = div_in.rem;
         assign dp = div_in.den;
         assign lp = div_in.low;
         assign qp = '0;
      end else begin : g_next
         assign rp = rem_ff[k-1];
         assign dp = den_ff[k-1];
         assign lp = low_ff[k-1];
         assign qp = quo_ff[k-1];
      end
      // bring down the next dividend bit, subtract when it fits
      assign t  = {rp, lp[QUO_BITS-1]};
      assign ge = t >= {1'b0, dp};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= ge ? DIV_W'(t - {1'b0, dp}) : DIV_W'(t);
            den_ff[k] <= dp;
            low_ff[k] <= lp << 1;
            quo_ff[k] <= {qp[QUO_BITS-2:0], ge};
         end
      end
   end

   assign quotient = quo_ff[QUO_BITS-1];

endmodule

`default_nettype wire

@@ hw/rtl/single_level_conductance.sv @@
// Top level of the single-level conductance evaluator: pipeline control and datapath.
// Depends on slc_pkg, slc_cordic and slc_div.
//
// Takes one request per cycle unless the output stalls and returns one result per
// request, in order (7 setup, 24 CORDIC rotation, 5 angle-to-dividend, 32 divider, 2
// mixing and output stages). The latency is set by the CORDIC, one rotation per stage,
// and by the restoring divider, one quotient bit per stage. The whole pipeline holds
// while the output register is full and not taken; req_ready follows. The user must
// write bias_division through the csr port only while idle; the block does not check.
`default_nettype none

module single_level_conductance import slc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [31:0] req_fermi_energy,
   input  wire logic signed [31:0] req_bias_voltage,
   input  wire logic signed [31:0] req_level_energy,
   input  wire logic [30:0]        req_left_coupling,
   input  wire logic [30:0]        req_right_coupling,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_conductance,
   output logic                    rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [16:0]        csr_bias_division
);

   logic [16:0]             bias_division_ff;
   logic [NUM_STAGES-1:0]   vld_ff;
   logic [NUM_STAGES-1:0]   vld_in;
   slc_item_type            pipe_ff [NUM_STAGES];
   slc_item_type            pipe_in [NUM_STAGES];
   logic                    adv;
   logic signed [Z_W-1:0]   z1;
   logic signed [Z_W-1:0]   z2;
   logic [QUO_BITS-1:0]     q_a;
   logic [QUO_BITS-1:0]     q_b;

   assign adv       = !vld_ff[ST_OUT] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_division_ff <= ETA_RESET;
      end else if (csr_valid) begin
         bias_division_ff <= csr_bias_division;
      end
   end

   slc_cordic u_cordic1 (
      .clock  (clock),
      .enable (adv),
      .x_in   (pipe_ff[ST_CORDIC-1].lane1.x),
      .y_in   (pipe_ff[ST_CORDIC-1].lane1.y),
      .z_out  (z1)
   );

   slc_cordic u_cordic2 (
      .clock  (clock),
      .enable (adv),
      .x_in   (pipe_ff[ST_CORDIC-1].lane2.x),
      .y_in   (pipe_ff[ST_CORDIC-1].lane2.y),
      .z_out  (z2)
   );

   slc_div u_div_a (
      .clock    (clock),
      .enable   (adv),
      .div_in   (pipe_ff[ST_DIVIN].div_a),
      .quotient (q_a)
   );

   slc_div u_div_b (
      .clock    (clock),
      .enable   (adv),
      .div_in   (pipe_ff[ST_DIVIN].div_b),
      .quotient (q_b)
   );

   always_comb begin
      slc_item_type       c;
      logic signed [49:0] rnd;
      logic signed [35:0] d_sel;
      logic [36:0]        two_u1;
      logic [36:0]        two_u2;
      logic [31:0]        lo_a;
      logic [31:0]        lo_b;
      logic [3:0]         hi_a;
      logic [3:0]         hi_b;
      logic [DIV_W-1:0]   sq_a;
      logic [DIV_W-1:0]   sq_b;
      logic [33:0]        mix;
      logic [31:0]        g;

      vld_in = {vld_ff[NUM_STAGES-2:0], req_valid};

      // capture
      pipe_in[0]     = '0;
      pipe_in[0].cmd = slc_cmd_type'(req_cmd);
      pipe_in[0].eta = (bias_division_ff > ETA_ONE) ? ETA_ONE : bias_division_ff;
      pipe_in[0].e   = req_fermi_energy;
      pipe_in[0].eps = req_level_energy;
      pipe_in[0].v   = req_bias_voltage;
      pipe_in[0].gl  = req_left_coupling;
      pipe_in[0].gr  = req_right_coupling;

      for (int k = 1; k < NUM_STAGES; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end

      // stage 1: eta*V, detuning, total coupling, coupling product
      c = pipe_ff[0];
      pipe_in[1].s     = 32'(c.gl) + 32'(c.gr);
      pipe_in[1].glgr  = c.gl * c.gr;
      pipe_in[1].dd    = 33'(c.e) - 33'(c.eps);
      pipe_in[1].aprod = $signed({1'b0, c.eta}) * c.v;
      pipe_in[1].fault = ((c.gl == '0) && (c.gr == '0))
                         || ((c.cmd == CMD_STATIC) && (c.v == '0));

      // stage 2: round eta*V half up
      c = pipe_ff[1];
      rnd = (c.aprod + 50'sd32768) >>> 16;
      pipe_in[2].a = 34'(rnd);

      // stage 3: shifted detunings
      c = pipe_ff[2];
      pipe_in[3].u1 = 36'(c.dd) + 36'(c.a);
      pipe_in[3].u2 = 36'(c.dd) + 36'(c.a) - 36'(c.v);

      // stage 4: magnitudes, CORDIC vectors
      c = pipe_ff[3];
      d_sel  = (c.cmd == CMD_TRANS) ? 36'(c.dd) : c.u1;
      two_u1 = 37'(abs36(c.u1)) << 1;
      two_u2 = 37'(abs36(c.u2)) << 1;
      pipe_in[4].mag_a   = abs36(d_sel);
      pipe_in[4].mag_b   = abs36(c.u2);
      pipe_in[4].lane1.x = CW'($signed({1'b0, c.s}));
      pipe_in[4].lane1.y = CW'(c.u1) <<< 1;
      pipe_in[4].lane1.m = MW'((two_u1 > 37'(c.s)) ? two_u1 : 37'(c.s));
      pipe_in[4].lane2.x = CW'($signed({1'b0, c.s}));
      pipe_in[4].lane2.y = CW'(c.u2) <<< 1;
      pipe_in[4].lane2.m = MW'((two_u2 > 37'(c.s)) ? two_u2 : 37'(c.s));

      // stage 5: coarse normalize, partial squares
      c = pipe_ff[4];
      lo_a = c.mag_a[31:0];
      hi_a = c.mag_a[35:32];
      lo_b = c.mag_b[31:0];
      hi_b = c.mag_b[35:32];
      pipe_in[5].lane1   = norm3(c.lane1, 32);
      pipe_in[5].lane2   = norm3(c.lane2, 32);
      pipe_in[5].sqa_lo  = lo_a * lo_a;
      pipe_in[5].sqa_mid = lo_a * hi_a;
      pipe_in[5].sqa_hi  = hi_a * hi_a;
      pipe_in[5].sqb_lo  = lo_b * lo_b;
      pipe_in[5].sqb_mid = lo_b * hi_b;
      pipe_in[5].sqb_hi  = hi_b * hi_b;
      pipe_in[5].ss      = c.s * c.s;

      // stage 6: fine normalize, transmission denominators
      c = pipe_ff[5];
      sq_a = (DIV_W'(c.sqa_hi) << 64) + (DIV_W'(c.sqa_mid) << 33) + DIV_W'(c.sqa_lo);
      sq_b = (DIV_W'(c.sqb_hi) << 64) + (DIV_W'(c.sqb_mid) << 33) + DIV_W'(c.sqb_lo);
      pipe_in[6].lane1 = norm3(c.lane1, 4);
      pipe_in[6].lane2 = norm3(c.lane2, 4);
      pipe_in[6].den_a = (sq_a << 2) + DIV_W'(c.ss);
      pipe_in[6].den_b = (sq_b << 2) + DIV_W'(c.ss);

      // angle difference and its sign against the bias
      pipe_in[ST_DZ].dz = z1 - z2;

      c = pipe_ff[ST_ABS-1];
      pipe_in[ST_ABS].abs_dz = c.dz[Z_W-1] ? Z_W'(-c.dz) : Z_W'(c.dz);
      pipe_in[ST_ABS].abs_v  = c.v[31] ? 32'(-c.v) : 32'(c.v);
      pipe_in[ST_ABS].sgn_ok = ((c.v > 0) && (c.dz > 0)) || ((c.v < 0) && (c.dz < 0));

      c = pipe_ff[ST_MUL-1];
      pipe_in[ST_MUL].plo   = c.glgr[31:0] * c.abs_dz;
      pipe_in[ST_MUL].phi   = c.glgr[61:32] * c.abs_dz;
      pipe_in[ST_MUL].den_s = c.abs_v * c.s;

      c = pipe_ff[ST_NUM-1];
      pipe_in[ST_NUM].num_s = ((NUM_W'(c.phi) << 32) + NUM_W'(c.plo)) << 2;

      // divider operands; a quotient of 2^32 or more saturates up front
      c = pipe_ff[ST_DIVIN-1];
      pipe_in[ST_DIVIN].sat = c.num_s >= (NUM_W'(c.den_s) << 32);
      if (c.cmd == CMD_STATIC) begin
         pipe_in[ST_DIVIN].div_a.rem = DIV_W'(c.num_s[95:32]);
         pipe_in[ST_DIVIN].div_a.den = DIV_W'(c.den_s);
         pipe_in[ST_DIVIN].div_a.low = c.num_s[31:0];
      end else begin
         pipe_in[ST_DIVIN].div_a.rem = DIV_W'(c.glgr) << 1;
         pipe_in[ST_DIVIN].div_a.den = c.den_a;
         pipe_in[ST_DIVIN].div_a.low = '0;
      end
      pipe_in[ST_DIVIN].div_b.rem = DIV_W'(c.glgr) << 1;
      pipe_in[ST_DIVIN].div_b.den = c.den_b;
      pipe_in[ST_DIVIN].div_b.low = '0;

      // eta weighting of the two transmissions
      c = pipe_ff[ST_MIX-1];
      pipe_in[ST_MIX].q_a = q_a;
      pipe_in[ST_MIX].pa  = c.eta * q_a;
      pipe_in[ST_MIX].pb  = (ETA_ONE - c.eta) * q_b;

      // result select
      c = pipe_ff[ST_OUT-1];
      mix = 34'((50'(c.pa) + 50'(c.pb) + 50'd32768) >> 16);
      case (c.cmd)
         CMD_TRANS:  g = c.q_a;
         CMD_STATIC: g = !c.sgn_ok ? '0 : ((c.sat || (c.q_a > ONE_Q31)) ? ONE_Q31 : c.q_a);
         CMD_DIFF:   g = (mix > 34'(ONE_Q31)) ? ONE_Q31 : 32'(mix);
         default:    g = '0;
      endcase
      if (c.cmd == CMD_NONE) begin
         pipe_in[ST_OUT].conductance = '0;
         pipe_in[ST_OUT].status      = 1'b0;
      end else if (c.fault) begin
         pipe_in[ST_OUT].conductance = '0;
         pipe_in[ST_OUT].status      = 1'b1;
      end else begin
         pipe_in[ST_OUT].conductance = g;
         pipe_in[ST_OUT].status      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_valid       = vld_ff[ST_OUT];
   assign rsp_conductance = pipe_ff[ST_OUT].conductance;
   assign rsp_status      = pipe_ff[ST_OUT].status;

   // hold every stage while the output is stalled
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during output stall");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_conductance == '0)
      else $error("fault status with nonzero conductance");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_conductance <= ONE_Q31)
      else $error("conductance above one");

   a_unused_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pipe_ff[ST_OUT].cmd == CMD_NONE)
      |-> (rsp_conductance == '0) && !rsp_status)
      else $error("unused command gave a result");

endmodule

`default_nettype wire

@@ tb/single_level_conductance_tb.sv @@
// Self-checking bench for the single-level conductance pipeline: random and directed requests,
// a bit-exact predictor in a small scoreboard class, and random stalls on both channels.
// Depends on slc_pkg and the single_level_conductance top level.
`default_nettype none

module single_level_conductance_tb import slc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int SQUEEZE_CYCLES = 400;
   localparam longint unsigned CAP_Q31 = 64'h8000_0000;

   // atan(2^-i), Q2.30, truncated
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct {
      slc_cmd_type        cmd;
      logic signed [31:0] energy;
      logic signed [31:0] bias;
      logic signed [31:0] level;
      logic [30:0]        gl;
      logic [30:0]        gr;
   } sample_type;

   typedef struct {
      logic [31:0] conductance;
      logic        status;
   } result_type;

   class conductance_board;
      logic [16:0] bias_division = ETA_RESET;
      result_type  pending[$];
      int          failures = 0;

      function longint unsigned magnitude(longint v);
         return v < 0 ? longint'(-v) : v;
      endfunction

      function longint unsigned transmission(longint d, logic [30:0] gl, logic [30:0] gr);
         logic [127:0] num, den, q;
         longint unsigned s, ad;
         s   = 64'(gl) + 64'(gr);
         ad  = magnitude(d);
         num = (128'(gl) * 128'(gr) * 128'd4) << 31;
         den = ((128'(ad) * 128'(ad)) << 2) + 128'(s) * 128'(s);
         q   = num / den;
         return q > 128'(CAP_Q31) ? CAP_Q31 : q[63:0];
      endfunction

      function longint angle(longint x, longint y);
         longint z, nx, ny, t;
         longint unsigned m;
         z = 0;
         m = longint'(x) > magnitude(y) ? x : magnitude(y);
         while (m < (64'd1 << 40)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
         end
         for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            t = longint'(ATAN_Q30[i]);
            if (y < 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - t;
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + t;
            end
            x = nx;
            y = ny;
         end
         return z;
      endfunction

      function result_type conductance_of(sample_type r);
         result_type res;
         longint e, v, eps, eta, a, u1, u2, dz;
         longint unsigned s, t1, t2, g;
         logic [127:0] num, den, q;
         e   = longint'(r.energy);
         v   = longint'(r.bias);
         eps = longint'(r.level);
         s   = 64'(r.gl) + 64'(r.gr);
         eta = bias_division > ETA_ONE ? 65536 : longint'(bias_division);
         a   = (eta * v + 32768) >>> 16;
         u1  = e - eps + a;
         u2  = u1 - v;
         res.conductance = '0;
         res.status      = 1'b0;
         if (r.cmd == CMD_NONE) begin
            return res;
         end
         if (s == 0 || (r.cmd == CMD_STATIC && v == 0)) begin
            res.status = 1'b1;
            return res;
         end
         case (r.cmd)
            CMD_TRANS: begin
               g = transmission(e - eps, r.gl, r.gr);
            end
            CMD_DIFF: begin
               t1 = transmission(u1, r.gl, r.gr);
               t2 = transmission(u2, r.gl, r.gr);
               g  = (longint'(eta) * t1 + longint'(65536 - eta) * t2 + 32768) >> 16;
               if (g > CAP_Q31) g = CAP_Q31;
            end
            default: begin
               g  = 0;
               dz = angle(longint'(s), 2 * u1) - angle(longint'(s), 2 * u2);
               if ((v > 0 && dz > 0) || (v < 0 && dz < 0)) begin
                  num = (128'(r.gl) * 128'(r.gr) * 128'd2 * 128'(magnitude(dz))) << 1;
                  den = 128'(magnitude(v)) * 128'(s);
                  q   = num / den;
                  g   = q > 128'(CAP_Q31) ? CAP_Q31 : q[63:0];
               end
            end
         endcase
         res.conductance = g[31:0];
         return res;
      endfunction

      function void note_request(sample_type r);
         pending.push_back(conductance_of(r));
      endfunction

      function void check_result(logic [31:0] conductance, logic status);
         result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: conductance %h status %b", conductance, status);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (conductance !== want.conductance) begin
            $error("conductance: expected %h, actual %h", want.conductance, conductance);
            failures++;
         end
         if (status !== want.status) begin
            $error("status: expected %b, actual %b", want.status, status);
            failures++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_cmd = '0;
   logic signed [31:0] req_fermi_energy = '0;
   logic signed [31:0] req_bias_voltage = '0;
   logic signed [31:0] req_level_energy = '0;
   logic [30:0]        req_left_coupling = '0;
   logic [30:0]        req_right_coupling = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_conductance;
   logic               rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [16:0]        csr_bias_division = '0;

   conductance_board board = new();
   bit squeeze = 1'b0;
   int idle_cycles = 0;

   single_level_conductance u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_fermi_energy   (req_fermi_energy),
      .req_bias_voltage   (req_bias_voltage),
      .req_level_energy   (req_level_energy),
      .req_left_coupling  (req_left_coupling),
      .req_right_coupling (req_right_coupling),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_conductance    (rsp_conductance),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_bias_division  (csr_bias_division)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check results and watch for a stuck pipeline
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_conductance, rsp_status);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver: stall pattern that switches among four random modes, plus one long hold-off
   initial begin
      int mode, span;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (squeeze) begin
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeeze = 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(50, 300);
            end
            span--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_request(sample_type r);
      req_valid          <= 1'b1;
      req_cmd            <= r.cmd;
      req_fermi_energy   <= r.energy;
      req_bias_voltage   <= r.bias;
      req_level_energy   <= r.level;
      req_left_coupling  <= r.gl;
      req_right_coupling <= r.gr;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
   endtask

   // drop valid for a random gap now and then; otherwise keep streaming
   task automatic send_with_gap(sample_type r, ref int burst);
      if (burst == 0) begin
         burst = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst--;
      send_request(r);
   endtask

   task automatic write_bias_division(logic [16:0] value);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_bias_division <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.bias_division = value;
   endtask

   function automatic logic signed [31:0] pick_energy();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom) >>> 6;
         2: return $signed($urandom) >>> 12;
         3: return $signed($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
         4: return '0;
         default: return $signed($urandom) >>> 3;
      endcase
   endfunction

   function automatic logic [30:0] pick_coupling();
      case ($urandom_range(0, 5))
         0: return 31'($urandom);
         1: return 31'($urandom >> 8);
         2: return 31'($urandom >> 14);
         3: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd1;
         4: return '0;
         default: return 31'($urandom >> 4);
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type r;
      r.cmd    = $urandom_range(0, 15) == 0 ? CMD_NONE : slc_cmd_type'($urandom_range(0, 2));
      r.energy = pick_energy();
      r.bias   = pick_energy();
      r.level  = pick_energy();
      r.gl     = pick_coupling();
      r.gr     = pick_coupling();
      return r;
   endfunction

   function automatic sample_type make_sample(slc_cmd_type cmd, logic signed [31:0] e,
                                              logic signed [31:0] v, logic signed [31:0] eps,
                                              logic [30:0] gl, logic [30:0] gr);
      sample_type r;
      r.cmd    = cmd;
      r.energy = e;
      r.bias   = v;
      r.level  = eps;
      r.gl     = gl;
      r.gr     = gr;
      return r;
   endfunction

   initial begin
      sample_type  directed[$];
      logic [16:0] settings[$];
      int burst;
      burst = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every command, zero coupling, zero bias, extremes of each field
      directed.push_back(make_sample(CMD_TRANS, 32'sh0100_0000, 0, 32'sh0100_0000,
                                     31'h0100_0000, 31'h0100_0000));
      directed.push_back(make_sample(CMD_STATIC, 0, 32'sh0080_0000, 0,
                                     31'h0080_0000, 31'h0100_0000));
      directed.push_back(make_sample(CMD_DIFF, 32'sh0020_0000, 32'sh0100_0000, 0,
                                     31'h0040_0000, 31'h0040_0000));
      directed.push_back(make_sample(CMD_NONE, 32'sh0100_0000, 32'sh0100_0000, 0,
                                     31'h0100_0000, 31'h0100_0000));
      for (int c = 0; c < 3; c++) begin
         directed.push_back(make_sample(slc_cmd_type'(c), 32'sh0100_0000, 32'sh0100_0000,
                                        0, 0, 0));
      end
      directed.push_back(make_sample(CMD_STATIC, 32'sh0100_0000, 0, 0,
                                     31'h0100_0000, 31'h0100_0000));
      directed.push_back(make_sample(CMD_STATIC, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                     31'h7FFF_FFFF, 31'h7FFF_FFFF));
      directed.push_back(make_sample(CMD_STATIC, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                     31'd1, 31'd1));
      directed.push_back(make_sample(CMD_STATIC, 32'sh0000_0100, -32'sh0000_0200, 0,
                                     31'h7FFF_FFFF, 31'd1));
      directed.push_back(make_sample(CMD_STATIC, 0, 32'sd1, 0, 31'd1, 31'd0));
      directed.push_back(make_sample(CMD_TRANS, 32'sh7FFF_FFFF, 0, 32'sh8000_0000,
                                     31'h7FFF_FFFF, 31'h7FFF_FFFF));
      directed.push_back(make_sample(CMD_TRANS, 32'sh8000_0000, 0, 32'sh7FFF_FFFF,
                                     31'd1, 31'd1));
      directed.push_back(make_sample(CMD_TRANS, 0, 0, 0, 31'h7FFF_FFFF, 31'd0));
      directed.push_back(make_sample(CMD_DIFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                     31'h7FFF_FFFF, 31'h7FFF_FFFF));
      directed.push_back(make_sample(CMD_DIFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                     31'd1, 31'h7FFF_FFFF));
      directed.push_back(make_sample(CMD_DIFF, 0, 0, 0, 31'h0000_1000, 31'h0000_1000));
      directed.push_back(make_sample(CMD_NONE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                     0, 0));
      foreach (directed[i]) send_request(directed[i]);

      // reset value first, then the extremes, above-one clamp and a few random settings
      settings = '{ETA_RESET, 17'd0, ETA_ONE, 17'h1FFFF, 17'd1, 17'($urandom_range(0, 65536)),
                   17'($urandom_range(65537, 131071)), 17'($urandom_range(0, 65536))};
      foreach (settings[p]) begin
         write_bias_division(settings[p]);
         if (p == 2) squeeze = 1'b1;
         repeat (220) send_with_gap(random_sample(), burst);
      end

      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/slc_pkg.sv
hw/rtl/slc_cordic.sv
hw/rtl/slc_div.sv
hw/rtl/single_level_conductance.sv
tb/single_level_conductance_tb.sv
